// File: rtl/core/cvn_pkg.sv
`default_nettype none
package cvn_pkg;

   localparam int MaxLenDefault = 64;
   localparam int ElemWidth     = 24;
   localparam int SumWidth      = 55;
   localparam int QuotWidth     = 23;

   typedef struct packed {
      logic signed [ElemWidth-1:0] elem_re;
      logic signed [ElemWidth-1:0] elem_im;
      logic                        is_last;
   } req_word_type;

   typedef struct packed {
      logic signed [ElemWidth-1:0] norm_re;
      logic signed [ElemWidth-1:0] norm_im;
      logic                        end_of_run;
      logic                        status;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic start;
      logic sel_im;
   } cvn_cmd_type;

   typedef struct packed {
      logic busy;
      logic sum_zero;
   } cvn_status_type;

endpackage
`default_nettype wire

// File: rtl/core/complex_vector_normalizer.sv
// Sequence: element words are loaded, the last word is followed by a check state,
// then each result is computed (with no search when both parts are zero) by
// bit-serial exact rounding, one quotient bit per multiply-and-compare pass on a 32x32 multiplier.
// Throughput: one word per cycle while loading; input stalls while emitting.
// Reset (synchronous, active high) clears the sum, count and control state.
`default_nettype none
module complex_vector_normalizer
   import cvn_pkg::*;
#(
   parameter int MaxLen = MaxLenDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data
);
   cvn_cmd_type    cmd;
   cvn_status_type stat;
   logic [$clog2(MaxLen)-1:0] wr_addr, rd_addr;
   logic [ElemWidth-1:0] res_re, res_im;
   logic end_r, err_r;

   // controller sequences load, per-element scaling and output words
   cvn_control #(.MaxLen(MaxLen)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_last(req_data.is_last), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_end(end_r),
      .rsp_err(err_r), .stat(stat), .cmd(cmd),
      .wr_addr(wr_addr), .rd_addr(rd_addr));

   cvn_datapath #(.MaxLen(MaxLen)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_data),
      .wr_addr(wr_addr), .rd_addr(rd_addr), .stat(stat),
      .res_re(res_re), .res_im(res_im));

   // error word carries zero payload
   assign rsp_data.norm_re    = err_r ? '0 : res_re;
   assign rsp_data.norm_im    = err_r ? '0 : res_im;
   assign rsp_data.end_of_run = end_r;
   assign rsp_data.status     = err_r;
endmodule
`default_nettype wire

// File: rtl/core/cvn_ram.sv
`default_nettype none
module cvn_ram #(
   parameter int Width = 48,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/cvn_scale.sv
`default_nettype none
// Binary search on round(t/(2 sqrt S)): one quotient bit per pass through SQ, M0 to M3 and CMP, exact compare
// (2q-1)^2*S <= t^2 built from four partial products of a 32x32 multiplier.
module cvn_scale
   import cvn_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [ElemWidth-1:0] x,
   input  wire logic [SumWidth-1:0]         s,
   output logic                             busy,
   output logic signed [ElemWidth-1:0]      y
);
   typedef enum logic [2:0] {S_IDLE, S_SQ, S_M0, S_M1, S_M2, S_M3, S_CMP} sc_state_type;

   sc_state_type      state_ff;
   logic [ElemWidth-1:0] q_ff, qt_ff, y_ff;
   logic [4:0]        bit_ff;
   logic              neg_ff;
   logic [47:0]       dd_ff;
   logic [109:0]      lhs_ff;
   logic [93:0]       rhs_ff;
   logic [31:0]       ma, mb;
   logic [63:0]       mp;
   logic [ElemWidth-1:0] mag;
   logic [23:0]       d;

   assign mag  = x[ElemWidth-1] ? ElemWidth'(-x) : ElemWidth'(x);
   assign d    = {qt_ff[22:0], 1'b0} - 24'd1;
   assign mp   = 64'(ma) * 64'(mb);
   assign busy = (state_ff != S_IDLE);
   assign y    = y_ff;

   // lhs = dd*S from four partials: lo*lo, hi*lo, lo*hi, hi*hi
   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         S_SQ:    begin ma = 32'(d);            mb = 32'(d); end
         S_M0:    begin ma = dd_ff[31:0];       mb = s[31:0]; end
         S_M1:    begin ma = 32'(dd_ff[47:32]); mb = s[31:0]; end
         S_M2:    begin ma = dd_ff[31:0];       mb = 32'(s[SumWidth-1:32]); end
         S_M3:    begin ma = 32'(dd_ff[47:32]); mb = 32'(s[SumWidth-1:32]); end
         default: begin ma = '0;                mb = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  neg_ff <= x[ElemWidth-1];
                  rhs_ff <= {48'(mag) * 48'(mag), 46'd0};
                  q_ff   <= '0;
                  bit_ff <= 5'd22;
                  qt_ff  <= 24'd1 << 22;
                  state_ff <= (mag == '0) ? S_IDLE : S_SQ;
                  y_ff <= '0;
               end
            end
            S_SQ: begin
               dd_ff    <= 48'(mp);
               state_ff <= S_M0;
            end
            S_M0: begin
               lhs_ff   <= 110'(mp);
               state_ff <= S_M1;
            end
            S_M1: begin
               lhs_ff   <= lhs_ff + (110'(mp) << 32);
               state_ff <= S_M2;
            end
            S_M2: begin
               lhs_ff   <= lhs_ff + (110'(mp) << 32);
               state_ff <= S_M3;
            end
            S_M3: begin
               lhs_ff   <= lhs_ff + (110'(mp) << 64);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (lhs_ff <= 110'(rhs_ff)) begin
                  q_ff <= qt_ff;
               end
               if (bit_ff == 5'd0) begin
                  y_ff <= neg_ff ? -((lhs_ff <= 110'(rhs_ff)) ? qt_ff : q_ff)
                                 :  ((lhs_ff <= 110'(rhs_ff)) ? qt_ff : q_ff);
                  state_ff <= S_IDLE;
               end else begin
                  qt_ff  <= ((lhs_ff <= 110'(rhs_ff)) ? qt_ff : q_ff)
                            | (24'd1 << (bit_ff - 5'd1));
                  bit_ff <= bit_ff - 5'd1;
                  state_ff <= S_SQ;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/cvn_datapath.sv
`default_nettype none
module cvn_datapath
   import cvn_pkg::*;
#(
   parameter int MaxLen = MaxLenDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cvn_cmd_type                 cmd,
   input  wire req_word_type                req,
   input  wire logic [$clog2(MaxLen)-1:0]   wr_addr,
   input  wire logic [$clog2(MaxLen)-1:0]   rd_addr,
   output cvn_status_type                   stat,
   output logic [ElemWidth-1:0]             res_re,
   output logic [ElemWidth-1:0]             res_im
);
   localparam int AW = $clog2(MaxLen);
   logic [SumWidth-1:0] sum_ff, sum_in;
   logic [47:0] rd_data;
   logic [ElemWidth-1:0] ar, am;
   logic b0, b1;

   assign ar = req.elem_re[ElemWidth-1] ? ElemWidth'(-req.elem_re) : ElemWidth'(req.elem_re);
   assign am = req.elem_im[ElemWidth-1] ? ElemWidth'(-req.elem_im) : ElemWidth'(req.elem_im);

   cvn_ram #(.Width(48), .Depth(MaxLen)) u_store (
      .clock(clock), .wr_en(cmd.load), .wr_addr(wr_addr[AW-1:0]),
      .wr_data({req.elem_im, req.elem_re}), .rd_addr(rd_addr), .rd_data(rd_data));

   always_comb begin
      sum_in = sum_ff;
      if (cmd.clear) sum_in = '0;
      else if (cmd.load)
         sum_in = sum_ff + SumWidth'(48'(ar) * 48'(ar)) + SumWidth'(48'(am) * 48'(am));
   end

   always_ff @(posedge clock) begin
      if (reset) sum_ff <= '0;
      else       sum_ff <= sum_in;
   end

   cvn_scale u_re (.clock(clock), .reset(reset), .start(cmd.start),
      .x(rd_data[23:0]), .s(sum_ff), .busy(b0), .y(res_re));
   cvn_scale u_im (.clock(clock), .reset(reset), .start(cmd.start),
      .x(rd_data[47:24]), .s(sum_ff), .busy(b1), .y(res_im));

   assign stat.busy     = b0 | b1 | cmd.sel_im;
   assign stat.sum_zero = (sum_ff == '0);
endmodule
`default_nettype wire

// File: rtl/core/cvn_control.sv
`default_nettype none
module cvn_control
   import cvn_pkg::*;
#(
   parameter int MaxLen = MaxLenDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_last,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_end,
   output logic                           rsp_err,
   input  wire cvn_status_type            stat,
   output cvn_cmd_type                    cmd,
   output logic [$clog2(MaxLen)-1:0]      wr_addr,
   output logic [$clog2(MaxLen)-1:0]      rd_addr
);
   localparam int AW = $clog2(MaxLen);
   typedef enum logic [2:0] {C_LOAD, C_CHECK, C_READ, C_START, C_WAIT, C_OUT} c_state_type;

   c_state_type state_ff;
   logic [AW:0] cnt_ff, idx_ff;
   logic        acc;

   assign req_stall = (state_ff != C_LOAD);
   assign acc       = req_valid && (state_ff == C_LOAD);
   assign wr_addr   = cnt_ff[AW-1:0];
   assign rd_addr   = idx_ff[AW-1:0];

   always_comb begin
      cmd        = '0;
      cmd.load   = acc && (cnt_ff < (AW+1)'(MaxLen));
      cmd.start  = (state_ff == C_START);
      cmd.clear  = (state_ff == C_CHECK && stat.sum_zero) ||
                   (state_ff == C_OUT && !rsp_stall && rsp_end);
      cmd.sel_im = (state_ff == C_READ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= C_LOAD;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         rsp_valid <= 1'b0;
         rsp_end   <= 1'b0;
         rsp_err   <= 1'b0;
      end else begin
         case (state_ff)
            C_LOAD: if (acc) begin
               if (cmd.load) cnt_ff <= cnt_ff + 1'b1;
               if (req_last) state_ff <= C_CHECK;
            end
            C_CHECK: begin
               idx_ff <= '0;
               if (stat.sum_zero) begin
                  rsp_valid <= 1'b1; rsp_end <= 1'b1; rsp_err <= 1'b1;
                  state_ff  <= C_OUT;
               end else state_ff <= C_READ;
            end
            C_READ:  state_ff <= C_START;
            C_START: state_ff <= C_WAIT;
            C_WAIT: if (!stat.busy) begin
               rsp_valid <= 1'b1; rsp_err <= 1'b0;
               rsp_end   <= (idx_ff + 1'b1 == cnt_ff);
               state_ff  <= C_OUT;
            end
            C_OUT: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               if (rsp_end) begin
                  cnt_ff <= '0; state_ff <= C_LOAD;
               end else begin
                  idx_ff <= idx_ff + 1'b1; state_ff <= C_READ;
               end
            end
            default: state_ff <= C_LOAD;
         endcase
      end
   end

   a_stall_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken during output");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(MaxLen)) else $error("count overflow");
   a_err_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_err) |-> rsp_end) else $error("error word not final");
endmodule
`default_nettype wire

// File: bench/complex_vector_normalizer_checker.sv
`timescale 1ns / 1ps
module complex_vector_normalizer_checker
   import cvn_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire req_word_type req_data,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rsp_word_type rsp_data,
   output int                fail_count,
   output int                pending_count
);

   localparam int VecDepth = 64;

   logic [47:0]  vec_store [VecDepth];
   logic [63:0]  energy;
   int           vec_len;
   rsp_word_type norm_queue [$];

   // exact round-half-away search: largest q with (2q-1)^2*s <= (2|x|*2^22)^2
   function automatic logic [23:0] scaled_part(logic [23:0] raw, logic [63:0] s);
      logic signed [23:0] x;
      logic [23:0]        mag;
      logic [127:0]       lhs, rhs;
      logic [63:0]        lo, hi, mid, d, t;
      x = raw;
      mag = x[23] ? 24'(-x) : 24'(x);
      if (mag == 0) return '0;
      t = 64'(mag) << 23;
      lo = 0;
      hi = 64'd1 << 22;
      rhs = 128'(t) * 128'(t);
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         d = 2 * mid - 1;
         lhs = 128'(d * d) * 128'(s);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return x[23] ? 24'(-lo) : 24'(lo);
   endfunction

   task automatic take_element(req_word_type w);
      logic signed [23:0] r, m;
      logic [63:0]        ar, am;
      rsp_word_type       o;
      r = w.elem_re;
      m = w.elem_im;
      if (vec_len < VecDepth) begin
         ar = r < 0 ? 64'(-64'(r)) : 64'(r);
         am = m < 0 ? 64'(-64'(m)) : 64'(m);
         vec_store[vec_len] = {w.elem_im, w.elem_re};
         energy += ar * ar + am * am;
         vec_len++;
      end
      if (!w.is_last) return;
      if (energy == 0) begin
         o = '0;
         o.end_of_run = 1'b1;
         o.status = 1'b1;
         norm_queue.push_back(o);
      end else begin
         for (int i = 0; i < vec_len; i++) begin
            o.norm_re = scaled_part(vec_store[i][23:0], energy);
            o.norm_im = scaled_part(vec_store[i][47:24], energy);
            o.end_of_run = (i + 1 == vec_len);
            o.status = 1'b0;
            norm_queue.push_back(o);
         end
      end
      energy = 0;
      vec_len = 0;
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         energy <= 0;
         vec_len <= 0;
         fail_count <= 0;
         norm_queue.delete();
      end else begin
         if (req_valid && !req_stall) take_element(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (norm_queue.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = norm_queue.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t: expected re %0d im %0d eor %b st %b, got re %0d im %0d eor %b st %b",
                     $time, e.norm_re, e.norm_im, e.end_of_run, e.status,
                     rsp_data.norm_re, rsp_data.norm_im, rsp_data.end_of_run,
                     rsp_data.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count = norm_queue.size();
   end

endmodule

// File: bench/complex_vector_normalizer_test.sv
`timescale 1ns / 1ps
module complex_vector_normalizer_test;
   import cvn_pkg::*;

   localparam int CycleLimit = 3_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   int           fail_count, pending_count;
   int           cycle_count = 0;
   bit           calm = 1'b0;      // last part of the run: no idling
   bit           hold_rsp = 1'b0;  // long receiver hold-off

   always #6 clock = ~clock;

   complex_vector_normalizer u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   complex_vector_normalizer_checker u_check (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .fail_count, .pending_count
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("complex_vector_normalizer_test: errors");
         $finish;
      end
   end

   // receiver: random stall bursts, or one long hold-off
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic logic [23:0] rand_part(int mode);
      case (mode)
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return '0;
         3: return 24'($signed($urandom_range(0, 64)) - 32);
         default: return 24'($urandom);
      endcase
   endfunction

   // one word, held until accepted; sender gaps come as random bursts
   task automatic send_element(logic [23:0] re, logic [23:0] im, bit last);
      req_word_type w;
      w.elem_re = re;
      w.elem_im = im;
      w.is_last = last;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock iff !req_stall);
   endtask

   task automatic send_vector(int len, int mode);
      for (int i = 0; i < len; i++)
         send_element(rand_part(mode == 5 ? $urandom_range(0, 4) : mode),
                      rand_part(mode == 5 ? $urandom_range(0, 4) : mode),
                      i == len - 1);
   endtask

   initial begin
      int sent, len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero norm, unit norm, single elements
      send_element(24'h800000, 24'h7FFFFF, 1'b1);
      send_element(24'h000000, 24'h000000, 1'b1);                 // zero norm
      send_element(24'h000000, 24'h000000, 1'b0);
      send_element(24'h000000, 24'h000000, 1'b1);
      send_element(24'h080000, 24'h080000, 1'b0);                 // unit norm: 0.5 each
      send_element(24'h080000, 24'hF80000, 1'b1);
      send_element(24'h000001, 24'hFFFFFF, 1'b1);
      send_element(24'h7FFFFF, 24'h000000, 1'b0);
      send_element(24'h000001, 24'h800000, 1'b1);
      send_vector(3, 2);
      send_vector(2, 0);

      // overlong vector: 64 kept, the rest dropped, a dropped last closes
      send_vector(70, 4);

      // long receiver hold-off while words keep coming
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            send_vector(64, 4);
            send_vector(5, 3);
         end
      join

      sent = 0;
      while (sent < 270) begin
         if (sent > 200) calm = 1'b1;
         case ($urandom_range(0, 9))
            0: len = 64;
            1: len = $urandom_range(60, 68);
            default: len = $urandom_range(1, 8);
         endcase
         send_vector(len, $urandom_range(0, 9) == 0 ? 2 : ($urandom_range(0, 3) == 0 ? 5 : 4));
         sent += len;
      end
      req_valid <= 1'b0;

      @(posedge clock iff pending_count == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("complex_vector_normalizer_test: clean");
      else
         $display("complex_vector_normalizer_test: errors");
      $finish;
   end

endmodule
